FILE: sv/path_corridor_merge_assert.svh
`ifndef PATH_CORRIDOR_MERGE_ASSERT_SVH
`define PATH_CORRIDOR_MERGE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define PCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define PCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pcm_pkg.sv
package pcm_pkg;

  localparam int PathDepth = 256;
  localparam int VisDepth  = 16;
  localparam int RefW      = 32;

  localparam int PathAw   = $clog2(PathDepth);
  localparam int PathCntW = $clog2(PathDepth + 1);
  localparam int VisAw    = $clog2(VisDepth);
  localparam int VisCntW  = $clog2(VisDepth + 1);

  localparam int CmdW    = 3;
  localparam int IdxW    = 8;
  localparam int LenW    = 9;
  localparam int StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND_PATH = 3'd0,
    CMD_APPEND_VIS  = 3'd1,
    CMD_MERGE       = 3'd2,
    CMD_READ        = 3'd3,
    CMD_CLEAR       = 3'd4
  } pcm_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } pcm_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PLAN,
    S_SETUP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_FILL,
    S_MERGE_END,
    S_DONE
  } pcm_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_finish;
    logic srch_rd;
    logic srch_cmp;
    logic plan;
    logic setup;
    logic move_rd;
    logic move_wr;
    logic fill;
    logic merge_end;
    logic load_out;
  } pcm_ctl_t;

  typedef struct packed {
    pcm_cmd_e cmd;
    logic     read_ok;
    logic     srch_empty;
    logic     hit;
    logic     srch_last;
    logic     move_needed;
    logic     move_last;
    logic     fill_last;
  } pcm_sts_t;

endpackage

FILE: sv/pcm_ifs.sv
interface pcm_in_if import pcm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [RefW-1:0] ref_value;
  logic [IdxW-1:0] read_index;

  modport source (output valid, cmd, ref_value, read_index, input ready);
  modport sink (input valid, cmd, ref_value, read_index, output ready);
endinterface

interface pcm_out_if import pcm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RefW-1:0]    ref_out;
  logic [LenW-1:0]    path_length;
  logic               match_found;
  logic [StatusW-1:0] status;

  modport source (output valid, ref_out, path_length, match_found, status, input ready);
  modport sink (input valid, ref_out, path_length, match_found, status, output ready);
endinterface

FILE: sv/pcm_ctrl.sv
`include "path_corridor_merge_assert.svh"

module pcm_ctrl import pcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  pcm_sts_t sts_i,
  output pcm_ctl_t ctl_o
);

  pcm_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        case (sts_i.cmd)
          CMD_READ:  state_d = sts_i.read_ok ? S_READ : S_DONE;
          CMD_MERGE: state_d = sts_i.srch_empty ? S_MERGE_END : S_SRCH_RD;
          default:   state_d = S_DONE;
        endcase
      end
      S_READ: begin
        ctl_o.rd_finish = 1'b1;
        state_d         = S_DONE;
      end
      S_SRCH_RD: begin
        ctl_o.srch_rd = 1'b1;
        state_d       = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        ctl_o.srch_cmp = 1'b1;
        if (sts_i.hit) begin
          state_d = S_PLAN;
        end else if (sts_i.srch_last) begin
          state_d = S_MERGE_END;
        end else begin
          state_d = S_SRCH_RD;
        end
      end
      S_PLAN: begin
        ctl_o.plan = 1'b1;
        state_d    = S_SETUP;
      end
      S_SETUP: begin
        ctl_o.setup = 1'b1;
        state_d     = sts_i.move_needed ? S_MOVE_RD : S_FILL;
      end
      S_MOVE_RD: begin
        ctl_o.move_rd = 1'b1;
        state_d       = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ctl_o.move_wr = 1'b1;
        state_d       = sts_i.move_last ? S_FILL : S_MOVE_RD;
      end
      S_FILL: begin
        ctl_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          state_d = S_MERGE_END;
        end
      end
      S_MERGE_END: begin
        ctl_o.merge_end = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl_o.load_out = 1'b1;
          in_ready_o     = 1'b1;
          if (in_valid_i) begin
            ctl_o.capture = 1'b1;
            state_d       = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  `PCM_ASSERT_NEXT(a_load_shows, ctl_o.load_out, out_valid_q, "result load not presented")
  `PCM_ASSERT_NEXT(a_cap_exec, ctl_o.capture, state_q == S_EXEC, "captured item not executed")
  `PCM_ASSERT_NOW(a_load_free, ctl_o.load_out, !out_valid_q || out_ready_i,
                  "output register overwritten")

endmodule

FILE: sv/pcm_dp.sv
`include "path_corridor_merge_assert.svh"

module pcm_dp import pcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pcm_ctl_t           ctl_i,
  output pcm_sts_t           sts_o,
  input  logic [CmdW-1:0]    in_cmd_i,
  input  logic [RefW-1:0]    in_ref_i,
  input  logic [IdxW-1:0]    in_idx_i,
  output logic [RefW-1:0]    out_ref_o,
  output logic [LenW-1:0]    out_len_o,
  output logic               out_match_o,
  output logic [StatusW-1:0] out_status_o
);

  localparam int CmpW = (PathCntW > IdxW) ? PathCntW : IdxW;
  localparam int SumW = PathCntW + 1;

  logic [RefW-1:0] path_mem [PathDepth];
  logic [RefW-1:0] rd_data_q;
  logic            rd_en;
  logic [PathAw-1:0] rd_addr;
  logic            wr_en;
  logic [PathAw-1:0] wr_addr;
  logic [RefW-1:0] wr_data;

  pcm_cmd_e        cmd_q;
  logic [RefW-1:0] ref_q;
  logic [IdxW-1:0] idx_q;

  logic [PathCntW-1:0] path_cnt_q;
  logic [VisCntW-1:0]  vis_cnt_q;
  logic [RefW-1:0]     vis_q [VisDepth];

  logic [PathAw-1:0]   ptr_q;
  logic                hit_q;
  logic [PathAw-1:0]   at_path_q;
  logic [VisAw-1:0]    at_vis_q;
  logic [VisCntW-1:0]  req_q;
  logic [PathCntW-1:0] orig_q, tail_q, new_len_q, mv_cnt_q;
  logic                right_q;
  logic [PathAw-1:0]   src_q, dst_q, fill_wr_q;
  logic [VisAw-1:0]    fill_vi_q;

  logic [RefW-1:0]    res_ref_q;
  pcm_status_e        res_status_q;
  logic               res_match_q;
  logic [RefW-1:0]    out_ref_q;
  logic [LenW-1:0]    out_len_q;
  logic               out_match_q;
  logic [StatusW-1:0] out_status_q;

  logic                path_full, vis_full, read_ok;
  logic                vis_hit;
  logic [VisAw-1:0]    vis_sel;
  logic [VisCntW-1:0]  req_c;
  logic [PathCntW-1:0] orig_c, tail_raw, tail_c;
  logic [SumW-1:0]     sum_c;

  assign path_full = path_cnt_q == PathCntW'(PathDepth);
  assign vis_full  = vis_cnt_q == VisCntW'(VisDepth);
  assign read_ok   = CmpW'(idx_q) < CmpW'(path_cnt_q);

  // lowest visited position equal to the path entry just read
  always_comb begin
    vis_hit = 1'b0;
    vis_sel = '0;
    for (int j = VisDepth - 1; j >= 0; j--) begin
      if ((VisCntW'(j) < vis_cnt_q) && (rd_data_q == vis_q[j])) begin
        vis_hit = 1'b1;
        vis_sel = VisAw'(j);
      end
    end
  end

  always_comb begin
    req_c    = vis_cnt_q - VisCntW'(at_vis_q);
    orig_c   = PathCntW'(at_path_q) + PathCntW'(1);
    tail_raw = path_cnt_q - orig_c;
    sum_c    = SumW'(req_c) + SumW'(tail_raw);
    if (sum_c > SumW'(PathDepth)) begin
      tail_c = PathCntW'(PathDepth) - PathCntW'(req_c);
    end else begin
      tail_c = tail_raw;
    end
  end

  always_comb begin
    sts_o.cmd         = cmd_q;
    sts_o.read_ok     = read_ok;
    sts_o.srch_empty  = (path_cnt_q == '0) || (vis_cnt_q == '0);
    sts_o.hit         = vis_hit;
    sts_o.srch_last   = ptr_q == '0;
    sts_o.move_needed = (tail_q != '0) && (PathCntW'(req_q) != orig_q);
    sts_o.move_last   = mv_cnt_q == PathCntW'(1);
    sts_o.fill_last   = PathCntW'(fill_wr_q) == (PathCntW'(req_q) - PathCntW'(1));
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = path_cnt_q[PathAw-1:0];
    wr_data = ref_q;
    if (ctl_i.exec && (cmd_q == CMD_APPEND_PATH) && !path_full) begin
      wr_en = 1'b1;
    end
    if (ctl_i.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = dst_q;
      wr_data = rd_data_q;
    end
    if (ctl_i.fill) begin
      wr_en   = 1'b1;
      wr_addr = fill_wr_q;
      wr_data = vis_q[fill_vi_q];
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = PathAw'(idx_q);
    if (ctl_i.exec && (cmd_q == CMD_READ)) begin
      rd_en = 1'b1;
    end
    if (ctl_i.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = ptr_q;
    end
    if (ctl_i.move_rd) begin
      rd_en   = 1'b1;
      rd_addr = src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      path_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= path_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      path_cnt_q <= '0;
      vis_cnt_q  <= '0;
    end else begin
      if (ctl_i.exec) begin
        case (cmd_q)
          CMD_APPEND_PATH: if (!path_full) path_cnt_q <= path_cnt_q + PathCntW'(1);
          CMD_APPEND_VIS:  if (!vis_full) vis_cnt_q <= vis_cnt_q + VisCntW'(1);
          CMD_CLEAR: begin
            path_cnt_q <= '0;
            vis_cnt_q  <= '0;
          end
          default: ;
        endcase
      end
      if (ctl_i.merge_end) begin
        vis_cnt_q <= '0;
        if (hit_q) begin
          path_cnt_q <= new_len_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q <= pcm_cmd_e'(in_cmd_i);
      ref_q <= in_ref_i;
      idx_q <= in_idx_i;
    end
    if (ctl_i.exec) begin
      res_ref_q    <= '0;
      res_match_q  <= 1'b0;
      res_status_q <= ST_OK;
      hit_q        <= 1'b0;
      ptr_q        <= PathAw'(path_cnt_q - PathCntW'(1));
      case (cmd_q)
        CMD_APPEND_PATH: if (path_full) res_status_q <= ST_FULL;
        CMD_APPEND_VIS: begin
          if (vis_full) begin
            res_status_q <= ST_FULL;
          end else begin
            vis_q[vis_cnt_q[VisAw-1:0]] <= ref_q;
          end
        end
        CMD_READ: if (!read_ok) res_status_q <= ST_RANGE;
        default: ;
      endcase
    end
    if (ctl_i.rd_finish) begin
      res_ref_q <= rd_data_q;
    end
    if (ctl_i.srch_cmp) begin
      if (vis_hit) begin
        hit_q     <= 1'b1;
        at_path_q <= ptr_q;
        at_vis_q  <= vis_sel;
      end else begin
        ptr_q <= ptr_q - PathAw'(1);
      end
    end
    if (ctl_i.plan) begin
      req_q     <= req_c;
      orig_q    <= orig_c;
      tail_q    <= tail_c;
      new_len_q <= PathCntW'(req_c) + tail_c;
      right_q   <= PathCntW'(req_c) > orig_c;
    end
    if (ctl_i.setup) begin
      // shift right walks down from the tail end, shift left walks up
      if (right_q) begin
        src_q <= PathAw'(orig_q + tail_q - PathCntW'(1));
        dst_q <= PathAw'(PathCntW'(req_q) + tail_q - PathCntW'(1));
      end else begin
        src_q <= PathAw'(orig_q);
        dst_q <= PathAw'(req_q);
      end
      mv_cnt_q  <= tail_q;
      fill_wr_q <= '0;
      fill_vi_q <= VisAw'(vis_cnt_q - VisCntW'(1));
    end
    if (ctl_i.move_wr) begin
      if (right_q) begin
        src_q <= src_q - PathAw'(1);
        dst_q <= dst_q - PathAw'(1);
      end else begin
        src_q <= src_q + PathAw'(1);
        dst_q <= dst_q + PathAw'(1);
      end
      mv_cnt_q <= mv_cnt_q - PathCntW'(1);
    end
    if (ctl_i.fill) begin
      fill_wr_q <= fill_wr_q + PathAw'(1);
      fill_vi_q <= fill_vi_q - VisAw'(1);
    end
    if (ctl_i.merge_end) begin
      res_match_q <= hit_q;
    end
    if (ctl_i.load_out) begin
      out_ref_q    <= res_ref_q;
      out_len_q    <= LenW'(path_cnt_q);
      out_match_q  <= res_match_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_ref_o    = out_ref_q;
  assign out_len_o    = out_len_q;
  assign out_match_o  = out_match_q;
  assign out_status_o = out_status_q;

  `PCM_ASSERT_NOW(a_path_cnt_max, 1'b1, path_cnt_q <= PathCntW'(PathDepth), "path count overflow")
  `PCM_ASSERT_NOW(a_vis_cnt_max, 1'b1, vis_cnt_q <= VisCntW'(VisDepth), "visited count overflow")
  `PCM_ASSERT_NEXT(a_vis_cleared, ctl_i.merge_end, vis_cnt_q == '0, "visited list not emptied")

endmodule

FILE: sv/path_corridor_merge.sv
// Path corridor merge: keeps a path list and a visited list of polygon refs.
// in_i (sink) takes one item per valid/ready handshake: cmd, ref_value,
// read_index. out_o (source) returns exactly one result item per input item:
// ref_out, path_length, match_found, status, in input order.
// Append, clear and unused codes: the item is captured, executed, then its
// result is loaded, and the next item can be taken as that result loads.
// Path read: one registered read of the path memory when in range; past
// the length the read step is skipped.
// Merge: a read and a compare per path entry searched; with a match, then
// a read and write per tail entry moved, a write per visited entry copied.
// The single read / single write port of the path memory sets the pace.
// Visited compares run in parallel.
// Reset clears both counts at once; the stores need no clearing pass.
// One finished result sits in the output register; if the receiver stalls,
// the next item is accepted and worked, then held in its final step until
// the output register frees up. No further item is taken meanwhile.
module path_corridor_merge import pcm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  pcm_in_if.sink   in_i,
  pcm_out_if.source out_o
);

  pcm_ctl_t ctl;
  pcm_sts_t sts;

  pcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  pcm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .in_cmd_i     (in_i.cmd),
    .in_ref_i     (in_i.ref_value),
    .in_idx_i     (in_i.read_index),
    .out_ref_o    (out_o.ref_out),
    .out_len_o    (out_o.path_length),
    .out_match_o  (out_o.match_found),
    .out_status_o (out_o.status)
  );

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

import pcm_pkg::*;

typedef struct {
  logic [RefW-1:0] ref_out;
  logic [LenW-1:0] path_len;
  logic            hit;
  pcm_status_e     status;
} corridor_result_t;

class corridor_scoreboard;
  logic [RefW-1:0]  path_mem [PathDepth];
  logic [RefW-1:0]  vis_mem [VisDepth];
  int               path_cnt;
  int               vis_cnt;
  corridor_result_t due_q [$];
  int               errors;
  int               results;
  int               merge_hits;
  int               merge_misses;
  int               clipped;
  int               full_drops;
  int               range_reads;

  // Splice visited refs (reversed) over the path prefix up to the latest common ref.
  function bit splice_visited();
    logic [RefW-1:0] moved [PathDepth];
    bit hit;
    int at_p;
    int at_v;
    int req;
    int orig;
    int tail;
    hit  = 1'b0;
    at_p = 0;
    at_v = 0;
    for (int i = path_cnt - 1; i >= 0 && !hit; i--) begin
      for (int j = 0; j < vis_cnt; j++) begin
        if (path_mem[i] == vis_mem[j]) begin
          hit  = 1'b1;
          at_p = i;
          at_v = j;
          break;
        end
      end
    end
    if (hit) begin
      req  = vis_cnt - at_v;
      orig = at_p + 1;
      tail = path_cnt - orig;
      if (req + tail > PathDepth) begin
        tail = PathDepth - req;
        clipped++;
      end
      for (int k = 0; k < tail; k++) moved[k] = path_mem[orig + k];
      for (int k = 0; k < tail; k++) path_mem[req + k] = moved[k];
      for (int k = 0; k < req; k++) path_mem[k] = vis_mem[vis_cnt - 1 - k];
      path_cnt = req + tail;
      merge_hits++;
    end else begin
      merge_misses++;
    end
    vis_cnt = 0;
    return hit;
  endfunction

  function void note_input(logic [CmdW-1:0] code, logic [RefW-1:0] value,
                           logic [IdxW-1:0] idx);
    corridor_result_t res;
    res.ref_out = '0;
    res.hit     = 1'b0;
    res.status  = ST_OK;
    case (code)
      CMD_APPEND_PATH: begin
        if (path_cnt < PathDepth) begin
          path_mem[path_cnt] = value;
          path_cnt++;
        end else begin
          res.status = ST_FULL;
          full_drops++;
        end
      end
      CMD_APPEND_VIS: begin
        if (vis_cnt < VisDepth) begin
          vis_mem[vis_cnt] = value;
          vis_cnt++;
        end else begin
          res.status = ST_FULL;
          full_drops++;
        end
      end
      CMD_MERGE: res.hit = splice_visited();
      CMD_READ: begin
        if (int'(idx) < path_cnt) begin
          res.ref_out = path_mem[idx];
        end else begin
          res.status = ST_RANGE;
          range_reads++;
        end
      end
      CMD_CLEAR: begin
        path_cnt = 0;
        vis_cnt  = 0;
      end
      default: ;
    endcase
    res.path_len = LenW'(path_cnt);
    due_q.push_back(res);
  endfunction

  function void flag(string field, logic [RefW-1:0] want, logic [RefW-1:0] got);
    errors++;
    if (errors <= 100)
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
  endfunction

  function void check_result(logic [RefW-1:0] ref_out, logic [LenW-1:0] path_len,
                             logic hit, logic [StatusW-1:0] status);
    corridor_result_t want;
    results++;
    if (due_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, ref_out %h len %0d", $time, ref_out, path_len);
      return;
    end
    want = due_q.pop_front();
    if (ref_out !== want.ref_out) flag("ref_out", want.ref_out, ref_out);
    if (path_len !== want.path_len)
      flag("path_length", RefW'(want.path_len), RefW'(path_len));
    if (hit !== want.hit) flag("match_found", RefW'(want.hit), RefW'(hit));
    if (status !== want.status) flag("status", RefW'(want.status), RefW'(status));
  endfunction
endclass

module tb_top;
  localparam logic [CmdW-1:0] CmdSpareLo  = 3'd5;
  localparam logic [CmdW-1:0] CmdSpareMid = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi  = 3'd7;
  localparam int ItemTarget = 900;
  localparam int CalmAfter  = 780;

  logic clk_i = 1'b0;
  logic rst_ni;

  pcm_in_if  in_if ();
  pcm_out_if out_if ();

  path_corridor_merge u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  corridor_scoreboard sb = new;

  int sent = 0;
  int gap_odds = 4;
  int ready_hold = 0;
  bit calm = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (calm) begin
      out_if.ready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_if.ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 14);
    end else begin
      out_if.ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 60);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.ref_out, out_if.path_length, out_if.match_found,
                      out_if.status);
  end

  task automatic send_item(input logic [CmdW-1:0] code, input logic [RefW-1:0] value,
                           input logic [IdxW-1:0] idx);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.cmd        <= code;
    in_if.ref_value  <= value;
    in_if.read_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(code, value, idx);
    sent++;
    if (sent >= CalmAfter) calm = 1'b1;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.due_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [RefW-1:0] path_ref();
    if (sb.path_cnt == 0) return $urandom;
    return sb.path_mem[$urandom_range(0, sb.path_cnt - 1)];
  endfunction

  function automatic logic [IdxW-1:0] read_at();
    if (sb.path_cnt > 0 && $urandom_range(0, 3) != 0)
      return IdxW'($urandom_range(0, sb.path_cnt - 1));
    return IdxW'($urandom_range(0, 255));
  endfunction

  // Typical steering round: load path, record visited polys, merge, sample.
  task automatic corridor_round();
    int n_path;
    int n_vis;
    logic [RefW-1:0] v;
    if ($urandom_range(0, 2) == 0) send_item(CMD_CLEAR, $urandom, IdxW'($urandom));
    n_path = $urandom_range(0, 20);
    n_vis  = $urandom_range(0, VisDepth + 1);
    repeat (n_path) send_item(CMD_APPEND_PATH, $urandom, IdxW'($urandom));
    for (int k = 0; k < n_vis; k++) begin
      case ($urandom_range(0, 5))
        0, 1: v = path_ref();
        2:    v = (k > 0 && sb.vis_cnt > 0) ? sb.vis_mem[$urandom_range(0, sb.vis_cnt - 1)]
                                             : $urandom;
        default: v = $urandom;
      endcase
      send_item(CMD_APPEND_VIS, v, IdxW'($urandom));
    end
    send_item(CMD_MERGE, $urandom, IdxW'($urandom));
    repeat ($urandom_range(0, 4)) send_item(CMD_READ, $urandom, read_at());
  endtask

  // Full path, then a merge whose result overflows and gets clipped.
  task automatic fill_and_clip();
    send_item(CMD_CLEAR, $urandom, IdxW'($urandom));
    while (sb.path_cnt < PathDepth) send_item(CMD_APPEND_PATH, $urandom, IdxW'($urandom));
    repeat (2) send_item(CMD_APPEND_PATH, $urandom, IdxW'($urandom));
    send_item(CMD_READ, $urandom, 8'hFF);
    send_item(CMD_APPEND_VIS, sb.path_mem[$urandom_range(0, 8)], IdxW'($urandom));
    repeat (VisDepth) send_item(CMD_APPEND_VIS, $urandom, IdxW'($urandom));
    send_item(CMD_MERGE, $urandom, IdxW'($urandom));
    send_item(CMD_READ, $urandom, 8'h00);
    send_item(CMD_READ, $urandom, 8'hFF);
    send_item(CMD_READ, $urandom, read_at());
  endtask

  initial begin
    bit filled;
    int pick;
    filled           = 1'b0;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_CLEAR;
    in_if.ref_value  = '0;
    in_if.read_index = '0;
    out_if.ready     = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed
    send_item(CMD_READ, 32'h0, 8'h00);
    send_item(CMD_MERGE, 32'h0, 8'h00);
    send_item(CmdSpareLo, 32'hFFFF_FFFF, 8'hFF);
    send_item(CmdSpareMid, 32'h1234_5678, 8'h0F);
    send_item(CmdSpareHi, 32'h0, 8'hF0);
    send_item(CMD_APPEND_PATH, 32'h0000_0000, 8'h00);
    send_item(CMD_APPEND_PATH, 32'hFFFF_FFFF, 8'hFF);
    send_item(CMD_APPEND_PATH, 32'h5A5A_A5A5, 8'h00);
    send_item(CMD_APPEND_PATH, 32'hA5A5_5A5A, 8'h00);
    send_item(CMD_READ, 32'h0, 8'h01);
    send_item(CMD_READ, 32'h0, 8'hFF);
    send_item(CMD_READ, 32'h0, 8'h04);
    send_item(CMD_APPEND_VIS, 32'h1234_5678, 8'h00);
    send_item(CMD_MERGE, 32'h0, 8'h00);
    send_item(CMD_APPEND_VIS, 32'hFFFF_FFFF, 8'h00);
    send_item(CMD_APPEND_VIS, 32'h0000_0000, 8'h00);
    send_item(CMD_APPEND_VIS, 32'hDEAD_BEEF, 8'h00);
    send_item(CMD_MERGE, 32'h0, 8'h00);
    send_item(CMD_READ, 32'h0, 8'h00);
    send_item(CMD_READ, 32'h0, 8'h04);
    send_item(CMD_CLEAR, 32'h0, 8'h00);
    send_item(CMD_READ, 32'h0, 8'h00);
    drain();

    // random
    while (sent < ItemTarget) begin
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      pick     = $urandom_range(0, 19);
      if (!filled && sent > 60) begin
        fill_and_clip();
        filled = 1'b1;
      end else if (pick < 2) begin
        repeat ($urandom_range(1, 8))
          send_item(CmdW'($urandom_range(0, 7)), $urandom, IdxW'($urandom_range(0, 255)));
      end else if (pick == 2) begin
        drain();
        corridor_round();
      end else begin
        corridor_round();
      end
    end

    in_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d items, %0d results; merges %0d matched, %0d unmatched, %0d clipped",
             sent, sb.results, sb.merge_hits, sb.merge_misses, sb.clipped);
    $display("dropped appends on full list %0d, reads past length %0d",
             sb.full_drops, sb.range_reads);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout, %0d results still due", sb.due_q.size());
    $display("tb_top: FAIL");
    $finish;
  end
endmodule
